// ----- hw/rtl/owsm_pkg.sv -----
// Shared widths, register indexes, division lane types and the sine table generator.
package owsm_pkg;

	localparam int SINE_TABLE_BITS_DEF = 10;

	localparam int SPEED_W   = 16;
	localparam int HEADING_W = 13;
	localparam int TARGET_W  = 24;
	localparam int LIMIT_W   = 15;
	localparam int GAIN_W    = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 16;

	localparam int TRIG_W    = 16;	// Q1.14 sine/cosine
	localparam int WGAIN_W   = 30;	// Q28 wheel gain
	localparam int PROD_W    = SPEED_W + WGAIN_W;
	localparam int WHEEL_W   = 19;
	localparam int WL_W      = WHEEL_W + LIMIT_W;
	localparam int A_W       = WL_W + 2;	// rounded division numerator
	localparam int DEN_W     = WHEEL_W;
	localparam int QUO_W     = 20;
	localparam int SCALED_W  = QUO_W;
	localparam int TPROD_W   = SCALED_W + GAIN_W + 1;
	localparam int NLANES    = 3;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_GAIN = 1'd1;

	localparam logic [LIMIT_W-1:0] MAX_SPEED_RST = 15'd1600;
	localparam logic [GAIN_W-1:0]  TICK_GAIN_RST = 16'd12924;

	// heading * 2^B / 5760: 5760 = 128 * 45, then reciprocal of 45 in Q30
	localparam int M_W       = 21;
	localparam int RECIP_W   = 25;
	localparam logic [RECIP_W-1:0] RECIP_45 = 25'd23860930;
	localparam int RECIP_SH  = 30;
	localparam int HALF_TURN = 2880;

	localparam longint unsigned Q30_ONE     = 64'd1073741824;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef struct packed {
		logic [A_W-1:0]            rem;
		logic [DEN_W-1:0]          den;
		logic                      neg;
		logic signed [WHEEL_W-1:0] wheel;
	} div_lane_t;

	typedef struct packed {
		logic vld;
		logic over;
	} div_ctl_t;

	// Quarter-wave sine entry in Q1.14, evaluated at elaboration only.
	function automatic logic [TRIG_W-1:0] quarter_sine(input int unsigned q,
			input int unsigned b);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned s;
		x  = (longint'(q) * HALF_PI_Q30 + (64'd1 << (b - 3))) >> (b - 2);
		x2 = (x * x) >> 30;
		t  = Q30_ONE - x2 / 72;
		t  = Q30_ONE - ((x2 * t) >> 30) / 42;
		t  = Q30_ONE - ((x2 * t) >> 30) / 20;
		t  = Q30_ONE - ((x2 * t) >> 30) / 6;
		s  = (x * t) >> 30;
		return TRIG_W'((s + 64'd32768) >> 16);
	endfunction

endpackage

// ----- hw/rtl/owsm_cmd_if.sv -----
// Motion command channel.
interface owsm_cmd_if;
	import owsm_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [SPEED_W-1:0] speed;
	logic [HEADING_W-1:0]      heading;
	logic signed [SPEED_W-1:0] turn;
	logic signed [SPEED_W-1:0] offset_left;
	logic signed [SPEED_W-1:0] offset_right;
	logic signed [SPEED_W-1:0] offset_rear;

	modport source(output valid, speed, heading, turn, offset_left, offset_right,
		offset_rear, input ready);
	modport sink(input valid, speed, heading, turn, offset_left, offset_right,
		offset_rear, output ready);
endinterface

// ----- hw/rtl/owsm_tgt_if.sv -----
// Wheel set-point result channel.
interface owsm_tgt_if;
	import owsm_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [TARGET_W-1:0] target_left;
	logic signed [TARGET_W-1:0] target_right;
	logic signed [TARGET_W-1:0] target_rear;
	logic                       was_scaled;

	modport source(output valid, target_left, target_right, target_rear, was_scaled,
		input ready);
	modport sink(input valid, target_left, target_right, target_rear, was_scaled,
		output ready);
endinterface

// ----- hw/rtl/omni_wheel_speed_mixer.sv -----
// Three-wheel omni base inverse kinematics: command in, three wheel set-points out.
// Path: stages S1 to S7, the divider, then S8 and S9, ending in the output register.
// Throughput: one command per cycle unless stalled; 20-stage divider, fully pipelined.
// A stalled output register freezes every stage at once; nothing is dropped or repeated.
// Reset (arst_n low, async): all valid bits clear, max_wheel_speed = 1600,
// tick_gain = 12924; the sine table is constant, so no clearing pass.
module omni_wheel_speed_mixer #(
	parameter int SINE_TABLE_BITS = owsm_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	owsm_cmd_if.sink                         cmd,
	owsm_tgt_if.source                       tgt,
	input  logic                             cfg_we,
	input  logic [owsm_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [owsm_pkg::CFG_W-1:0]       cfg_wdata
);
	import owsm_pkg::*;

	localparam int B       = SINE_TABLE_BITS;
	localparam int QUARTER = 1 << (B - 2);
	localparam int N_W     = HEADING_W + B + 1;
	localparam int P_W     = M_W + RECIP_W;

	localparam logic signed [TRIG_W-1:0]  ROOT3_HALF = 16'sd14189;
	localparam logic signed [PROD_W-1:0]  HALF_Q28   = PROD_W'(64'sd134217728);
	localparam logic signed [TPROD_W-1:0] HALF_Q12   = TPROD_W'(64'sd2048);
	localparam logic signed [TPROD_W-1:0] OUT_MAX    = TPROD_W'(64'sd8388607);
	localparam logic signed [TPROD_W-1:0] OUT_MIN    = -TPROD_W'(64'sd8388608);

	// ---------------- configuration registers ----------------
	logic [LIMIT_W-1:0] max_speed_q;
	logic [GAIN_W-1:0]  tick_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q <= MAX_SPEED_RST;
			tick_gain_q <= TICK_GAIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MAX_SPEED: max_speed_q <= cfg_wdata[LIMIT_W-1:0];
				REG_TICK_GAIN: tick_gain_q <= cfg_wdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- quarter-wave sine table (constant) ----------------
	logic [TRIG_W-1:0] qtab [QUARTER+1];
	for (genvar q = 0; q <= QUARTER; q++) begin : g_tab
		assign qtab[q] = quarter_sine(q, B);
	end

	function automatic logic signed [TRIG_W-1:0] lookup(input logic [B-1:0] idx);
		logic [1:0]   quad;
		logic [B-3:0] r;
		logic [B-2:0] qi;
		logic [TRIG_W-1:0] mag;
		quad = idx[B-1:B-2];
		r    = idx[B-3:0];
		qi   = quad[0] ? ((B-1)'(QUARTER) - (B-1)'(r)) : (B-1)'(r);
		mag  = qtab[qi];
		return quad[1] ? -$signed(mag) : $signed(mag);
	endfunction

	// Whole pipeline advances together when the output register is free or drained.
	logic adv;
	logic v_s9;
	assign adv       = !v_s9 || tgt.ready;
	assign cmd.ready = adv;

	// ---------------- S1: phase numerator times 1/45 ----------------
	logic                      v_s1;
	logic [P_W-1:0]            pprod_s1;
	logic signed [SPEED_W-1:0] speed_s1, turn_s1;
	logic signed [SPEED_W-1:0] off_s1 [NLANES];
	logic [N_W-1:0]            num_ph;
	logic [M_W-1:0]            m_ph;

	// (heading * 2^B + 2880) / 128, then / 45 by reciprocal (exact over this range)
	assign num_ph = (N_W'(cmd.heading) << B) + N_W'(HALF_TURN);
	assign m_ph   = M_W'(num_ph >> 7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= cmd.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pprod_s1 <= P_W'(m_ph) * P_W'(RECIP_45);
			speed_s1 <= cmd.speed;
			turn_s1  <= cmd.turn;
			off_s1[0] <= cmd.offset_left;
			off_s1[1] <= cmd.offset_right;
			off_s1[2] <= cmd.offset_rear;
		end
	end

	// ---------------- S2: sine and cosine lookup ----------------
	logic                      v_s2;
	logic signed [TRIG_W-1:0]  sin_s2, cos_s2;
	logic signed [SPEED_W-1:0] speed_s2, turn_s2;
	logic signed [SPEED_W-1:0] off_s2 [NLANES];
	logic [B-1:0]              phase;

	assign phase = pprod_s1[RECIP_SH +: B];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sin_s2   <= lookup(phase);
			cos_s2   <= lookup(phase + B'(QUARTER));
			speed_s2 <= speed_s1;
			turn_s2  <= turn_s1;
			off_s2   <= off_s1;
		end
	end

	// ---------------- S3: per-wheel gains, Q28 ----------------
	logic                       v_s3;
	logic signed [WGAIN_W-1:0]  g_s3 [NLANES];
	logic signed [SPEED_W-1:0]  speed_s3, turn_s3;
	logic signed [SPEED_W-1:0]  off_s3 [NLANES];
	logic signed [WGAIN_W-1:0]  c_term, s_half;

	assign c_term = WGAIN_W'(cos_s2) * WGAIN_W'(ROOT3_HALF);
	assign s_half = WGAIN_W'(sin_s2) <<< 13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			g_s3[0]  <= -c_term - s_half;
			g_s3[1]  <= c_term - s_half;
			g_s3[2]  <= WGAIN_W'(sin_s2) <<< 14;
			speed_s3 <= speed_s2;
			turn_s3  <= turn_s2;
			off_s3   <= off_s2;
		end
	end

	// ---------------- S4: speed times gain ----------------
	logic                      v_s4;
	logic signed [PROD_W-1:0]  prod_s4 [NLANES];
	logic signed [SPEED_W-1:0] turn_s4;
	logic signed [SPEED_W-1:0] off_s4 [NLANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < NLANES; l++)
				prod_s4[l] <= PROD_W'(speed_s3) * PROD_W'(g_s3[l]);
			turn_s4 <= turn_s3;
			off_s4  <= off_s3;
		end
	end

	// ---------------- S5: wheel = offset + turn + rounded term ----------------
	logic                      v_s5;
	logic signed [WHEEL_W-1:0] wheel_s5 [NLANES];
	logic signed [PROD_W-1:0]  term [NLANES];

	always_comb begin
		for (int l = 0; l < NLANES; l++)
			term[l] = (prod_s4[l] + HALF_Q28) >>> 28;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (adv) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < NLANES; l++)
				wheel_s5[l] <= WHEEL_W'(off_s4[l]) + WHEEL_W'(turn_s4) + WHEEL_W'(term[l]);
		end
	end

	// ---------------- S6: limit check, largest wheel, wheel * limit ----------------
	logic                      v_s6, over_s6;
	logic signed [WHEEL_W-1:0] wheel_s6 [NLANES];
	logic signed [WHEEL_W-1:0] largest_s6;
	logic signed [WL_W-1:0]    wl_s6 [NLANES];
	logic signed [WHEEL_W-1:0] lim_x, big01, big;
	logic                      over;

	assign lim_x = WHEEL_W'({1'b0, max_speed_q});
	assign big01 = (wheel_s5[1] > wheel_s5[0]) ? wheel_s5[1] : wheel_s5[0];
	assign big   = (wheel_s5[2] > big01) ? wheel_s5[2] : big01;
	// only positive excess triggers scaling
	assign over  = (wheel_s5[0] > lim_x) || (wheel_s5[1] > lim_x) || (wheel_s5[2] > lim_x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (adv) v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			over_s6    <= over;
			largest_s6 <= big;
			wheel_s6   <= wheel_s5;
			for (int l = 0; l < NLANES; l++)
				wl_s6[l] <= WL_W'(wheel_s5[l]) * WL_W'(lim_x);
		end
	end

	// ---------------- S7: rounded-division operands ----------------
	// round(n/d) = floor((2n+d)/2d); negative numerators divide the magnitude
	// -num + den - 1, which is ~num + den in two's complement.
	logic                      v_s7, over_s7;
	div_lane_t                 lane_s7 [NLANES];
	logic signed [A_W-1:0]     num [NLANES];
	logic [DEN_W-1:0]          den;

	assign den = {largest_s6[WHEEL_W-2:0], 1'b0};

	always_comb begin
		for (int l = 0; l < NLANES; l++)
			num[l] = (A_W'(wl_s6[l]) <<< 1) + A_W'(largest_s6);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (adv) v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			over_s7 <= over_s6;
			for (int l = 0; l < NLANES; l++) begin
				lane_s7[l].neg   <= num[l][A_W-1];
				lane_s7[l].rem   <= num[l][A_W-1] ? (~A_W'(num[l]) + A_W'(den))
				                                  : A_W'(num[l]);
				lane_s7[l].den   <= den;
				lane_s7[l].wheel <= wheel_s6[l];
			end
		end
	end

	// ---------------- divider: 20 stages ----------------
	div_ctl_t         ctl_d7, ctl_dq;
	div_lane_t        lane_dq [NLANES];
	logic [QUO_W-1:0] quo_dq  [NLANES];

	assign ctl_d7.vld  = v_s7;
	assign ctl_d7.over = over_s7;

	owsm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.ctl_in   (ctl_d7),
		.lane_in  (lane_s7),
		.ctl_out  (ctl_dq),
		.lane_out (lane_dq),
		.quo_out  (quo_dq)
	);

	// ---------------- S8: pick scaled or raw wheel, times tick gain ----------------
	logic                       v_s8, scaled_s8;
	logic signed [TPROD_W-1:0]  tprod_s8 [NLANES];
	logic signed [SCALED_W-1:0] wsel [NLANES];

	always_comb begin
		for (int l = 0; l < NLANES; l++) begin
			if (ctl_dq.over)
				wsel[l] = lane_dq[l].neg ? -$signed(quo_dq[l]) : $signed(quo_dq[l]);
			else
				wsel[l] = SCALED_W'(lane_dq[l].wheel);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else if (adv) v_s8 <= ctl_dq.vld;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			scaled_s8 <= ctl_dq.over;
			for (int l = 0; l < NLANES; l++)
				tprod_s8[l] <= TPROD_W'(wsel[l]) * TPROD_W'({1'b0, tick_gain_q});
		end
	end

	// ---------------- S9: round, saturate, output register ----------------
	logic signed [TARGET_W-1:0] tgt_s9 [NLANES];
	logic                       scaled_s9;
	logic signed [TPROD_W-1:0]  rnd [NLANES];

	always_comb begin
		for (int l = 0; l < NLANES; l++)
			rnd[l] = (tprod_s8[l] + HALF_Q12) >>> 12;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s9 <= 1'b0;
		else if (adv) v_s9 <= v_s8;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			scaled_s9 <= scaled_s8;
			for (int l = 0; l < NLANES; l++) begin
				if (rnd[l] > OUT_MAX)
					tgt_s9[l] <= TARGET_W'(OUT_MAX);
				else if (rnd[l] < OUT_MIN)
					tgt_s9[l] <= TARGET_W'(OUT_MIN);
				else
					tgt_s9[l] <= TARGET_W'(rnd[l]);
			end
		end
	end

	assign tgt.valid        = v_s9;
	assign tgt.target_left  = tgt_s9[0];
	assign tgt.target_right = tgt_s9[1];
	assign tgt.target_rear  = tgt_s9[2];
	assign tgt.was_scaled   = scaled_s9;

endmodule

// ----- hw/rtl/owsm_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, three lanes in step.
module owsm_div (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  owsm_pkg::div_ctl_t                     ctl_in,
	input  owsm_pkg::div_lane_t                    lane_in [owsm_pkg::NLANES],
	output owsm_pkg::div_ctl_t                     ctl_out,
	output owsm_pkg::div_lane_t                    lane_out [owsm_pkg::NLANES],
	output logic [owsm_pkg::QUO_W-1:0]             quo_out [owsm_pkg::NLANES]
);
	import owsm_pkg::*;

	localparam int TRIAL_W = A_W + QUO_W;

	div_ctl_t            ctl_s  [QUO_W+1];
	div_lane_t           lane_s [QUO_W+1][NLANES];
	logic [QUO_W-1:0]    quo_s  [QUO_W+1][NLANES];

	always_comb begin
		ctl_s[0] = ctl_in;
		for (int l = 0; l < NLANES; l++) begin
			lane_s[0][l] = lane_in[l];
			quo_s[0][l]  = '0;
		end
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		localparam int BIT = QUO_W - 1 - k;
		div_lane_t        nxt [NLANES];
		logic [QUO_W-1:0] qn  [NLANES];

		always_comb begin
			for (int l = 0; l < NLANES; l++) begin
				logic [TRIAL_W-1:0] trial;
				logic [TRIAL_W-1:0] remx;
				trial  = TRIAL_W'(lane_s[k][l].den) << BIT;
				remx   = TRIAL_W'(lane_s[k][l].rem);
				nxt[l] = lane_s[k][l];
				qn[l]  = quo_s[k][l];
				if (remx >= trial) begin
					nxt[l].rem = A_W'(remx - trial);
					qn[l][BIT] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k+1] <= '0;
			end else if (en) begin
				ctl_s[k+1] <= ctl_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < NLANES; l++) begin
					lane_s[k+1][l] <= nxt[l];
					quo_s[k+1][l]  <= qn[l];
				end
			end
		end
	end

	always_comb begin
		ctl_out = ctl_s[QUO_W];
		for (int l = 0; l < NLANES; l++) begin
			lane_out[l] = lane_s[QUO_W][l];
			quo_out[l]  = quo_s[QUO_W][l];
		end
	end

endmodule

// ----- hw/rtl/owsm_chk.sv -----
// Port-level checks for the omni wheel speed mixer, bound to the top level.
module owsm_chk (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    cmd_ready,
	input logic                                    tgt_valid,
	input logic                                    tgt_ready,
	input logic signed [owsm_pkg::TARGET_W-1:0]    target_left,
	input logic                                    was_scaled
);
	import owsm_pkg::*;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tgt_valid && !tgt_ready |=> tgt_valid && $stable(target_left) && $stable(was_scaled))
		else $error("stalled result changed");

	// input side is ready exactly when the output register can move
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_ready == (!tgt_valid || tgt_ready))
		else $error("ready does not follow output stall");

	// output register only loads on a pipeline advance
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(tgt_valid) |-> $past(cmd_ready))
		else $error("result appeared without pipeline advance");

endmodule

bind omni_wheel_speed_mixer owsm_chk u_owsm_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_ready   (cmd.ready),
	.tgt_valid   (tgt.valid),
	.tgt_ready   (tgt.ready),
	.target_left (tgt.target_left),
	.was_scaled  (tgt.was_scaled)
);
